// ===== rtl/aems_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aems_pkg: shared types and constants for the asymmetric EMA light smoother
// Alpha format, configuration register indexes and the alpha set carried
// from the register file to the channel datapaths.
// ----------------------------------------------------------------------------
package aems_pkg;

  // Alphas are unsigned with 16 fraction bits; 65536 stands for 1.0.
  localparam int ALPHA_BITS = 16;
  localparam int ALPHA_W    = ALPHA_BITS + 1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1) << ALPHA_BITS;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);

  // The index field is one bit wider than the register list needs, so
  // writes beyond the list can arrive and are dropped.
  localparam int CFG_INDEX_BITS = 4;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WHITE_RISE = 4'd0,
    REG_WHITE_FALL = 4'd1,
    REG_RGB_RISE   = 4'd2,
    REG_RGB_FALL   = 4'd3,
    REG_SATURATION = 4'd4,
    REG_HUE        = 4'd5,
    REG_CENTER     = 4'd6,
    REG_WIDTH      = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] white_rise;
    logic [ALPHA_W-1:0] white_fall;
    logic [ALPHA_W-1:0] rgb_rise;
    logic [ALPHA_W-1:0] rgb_fall;
    logic [ALPHA_W-1:0] saturation;
    logic [ALPHA_W-1:0] hue;
    logic [ALPHA_W-1:0] center;
    logic [ALPHA_W-1:0] width;
  } alpha_set_t;

endpackage

// ===== rtl/aems_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aems_if: channel interfaces of the asymmetric EMA light smoother
// Goal channel, result channel and configuration write channel, each with
// a valid/ready handshake.
// ----------------------------------------------------------------------------
interface aems_goal_if #(
  parameter int LEVEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  restart;
  logic [LEVEL_BITS-1:0] goal_white;
  logic [LEVEL_BITS-1:0] goal_rgb;
  logic [LEVEL_BITS-1:0] goal_saturation;
  logic [LEVEL_BITS-1:0] goal_hue;
  logic [LEVEL_BITS-1:0] goal_center;
  logic [LEVEL_BITS-1:0] goal_width;

  modport source (
    output valid, restart, goal_white, goal_rgb, goal_saturation, goal_hue,
           goal_center, goal_width,
    input  ready
  );
  modport sink (
    input  valid, restart, goal_white, goal_rgb, goal_saturation, goal_hue,
           goal_center, goal_width,
    output ready
  );
endinterface

interface aems_result_if #(
  parameter int LEVEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] out_white;
  logic [LEVEL_BITS-1:0] out_rgb;
  logic [LEVEL_BITS-1:0] out_saturation;
  logic [LEVEL_BITS-1:0] out_hue;
  logic [LEVEL_BITS-1:0] out_center;
  logic [LEVEL_BITS-1:0] out_width;

  modport source (
    output valid, out_white, out_rgb, out_saturation, out_hue, out_center,
           out_width,
    input  ready
  );
  modport sink (
    input  valid, out_white, out_rgb, out_saturation, out_hue, out_center,
           out_width,
    output ready
  );
endinterface

interface aems_cfg_if;
  import aems_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] reg_index;
  logic [ALPHA_W-1:0]        data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// ===== rtl/aems_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aems_cfg_regs: alpha register file
// Eight 17-bit alpha registers written over the configuration channel.
// ----------------------------------------------------------------------------
module aems_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  aems_cfg_if.sink            cfg,
  output aems_pkg::alpha_set_t alphas
);
  import aems_pkg::*;

  alpha_set_t regs;

  // Writes are always taken; an index past the list is dropped.
  assign cfg.ready = 1'b1;
  assign alphas    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{default: ALPHA_RESET};
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_WHITE_RISE: regs.white_rise <= cfg.data;
        REG_WHITE_FALL: regs.white_fall <= cfg.data;
        REG_RGB_RISE:   regs.rgb_rise   <= cfg.data;
        REG_RGB_FALL:   regs.rgb_fall   <= cfg.data;
        REG_SATURATION: regs.saturation <= cfg.data;
        REG_HUE:        regs.hue        <= cfg.data;
        REG_CENTER:     regs.center     <= cfg.data;
        REG_WIDTH:      regs.width      <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/aems_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aems_channel: one smoothing step for a single channel
// Computes held + floor((goal - held) * alpha / 2^16), either as a plain
// level with rise/fall alphas or as a circular hue on the shortest path.
// ----------------------------------------------------------------------------
module aems_channel #(
  parameter int LEVEL_BITS = 16,
  parameter bit CIRCULAR   = 1'b0
) (
  input  logic [LEVEL_BITS-1:0]        cur,
  input  logic [LEVEL_BITS-1:0]        goal,
  input  logic [aems_pkg::ALPHA_W-1:0] rise_alpha,
  input  logic [aems_pkg::ALPHA_W-1:0] fall_alpha,
  output logic [LEVEL_BITS-1:0]        next
);
  import aems_pkg::*;

  localparam int DIFF_W = LEVEL_BITS + 1;
  localparam int PROD_W = DIFF_W + ALPHA_W + 1;

  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  delta;
  logic                      rising;
  logic [ALPHA_W-1:0]        alpha_raw;
  logic [ALPHA_W-1:0]        alpha;
  logic signed [PROD_W-1:0]  prod;

  assign diff   = $signed({1'b0, goal}) - $signed({1'b0, cur});
  assign rising = (goal >= cur);

  // Hue uses its one alpha in both directions.
  assign alpha_raw = (CIRCULAR || rising) ? rise_alpha : fall_alpha;
  // Anything above 1.0 behaves as 1.0.
  assign alpha     = alpha_raw[ALPHA_BITS] ? ALPHA_ONE : alpha_raw;

  generate
    if (CIRCULAR) begin : g_hue
      logic [LEVEL_BITS-1:0] wrapped;
      logic                  tie;
      // Low bits give the difference modulo one turn. Sign-extending them
      // picks the short way round; at exactly half a turn the sign of the
      // raw difference is kept instead.
      assign wrapped = diff[LEVEL_BITS-1:0];
      assign tie     = (wrapped == {1'b1, {(LEVEL_BITS-1){1'b0}}});
      assign delta   = $signed({tie ? diff[LEVEL_BITS] : wrapped[LEVEL_BITS-1], wrapped});
    end else begin : g_level
      assign delta = diff;
    end
  endgenerate

  // Arithmetic shift of the signed product rounds toward minus infinity.
  assign prod = PROD_W'(delta) * PROD_W'($signed({1'b0, alpha}));
  assign next = cur + prod[ALPHA_BITS +: LEVEL_BITS];

endmodule

// ===== rtl/asymmetric_ema_light_smoother.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asymmetric_ema_light_smoother: six-channel exponential smoother
// Moves white, RGB, saturation, hue, centre and width toward each goal item
// with per-channel alphas; white and RGB rise and fall at separate rates.
// ----------------------------------------------------------------------------
// Usage:
//   goal   - valid/ready channel carrying one goal item and a restart flag.
//   result - valid/ready channel carrying the six smoothed values.
//   cfg    - valid/ready write channel for the eight alpha registers; always
//            ready. Write only while the block is idle.
// Each accepted goal yields exactly one result transfer. A goal is captured
// in the input register, then the six channel steps run in a single pass
// into the held-value registers, which also drive the result payload.
// Result valid rises once the goal moves from the input register into the
// held values. A new goal transfer can be taken every cycle while the
// result is empty or being taken; each goal needs one multiply-add per
// channel between the input register and the held values.
// Reset clears the alphas to 6554 (about 0.1), empties both stages and marks
// the history as empty, so the first goal after reset is copied straight
// through, as is any goal with restart set.
// When the receiver stalls, the result holds and the pending goal waits in
// the input register; goal ready drops only while both stages are full and
// the result is not being taken.
// ----------------------------------------------------------------------------
module asymmetric_ema_light_smoother #(
  parameter int LEVEL_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  aems_goal_if.sink      goal,
  aems_result_if.source  result,
  aems_cfg_if.sink       cfg
);
  import aems_pkg::*;

  alpha_set_t alphas;

  // Input register.
  logic                  in_valid;
  logic                  in_restart;
  logic [LEVEL_BITS-1:0] in_white;
  logic [LEVEL_BITS-1:0] in_rgb;
  logic [LEVEL_BITS-1:0] in_saturation;
  logic [LEVEL_BITS-1:0] in_hue;
  logic [LEVEL_BITS-1:0] in_center;
  logic [LEVEL_BITS-1:0] in_width;

  // Held values; these double as the result register.
  logic                  out_valid;
  logic                  primed;
  logic [LEVEL_BITS-1:0] held_white;
  logic [LEVEL_BITS-1:0] held_rgb;
  logic [LEVEL_BITS-1:0] held_saturation;
  logic [LEVEL_BITS-1:0] held_hue;
  logic [LEVEL_BITS-1:0] held_center;
  logic [LEVEL_BITS-1:0] held_width;

  logic [LEVEL_BITS-1:0] step_white;
  logic [LEVEL_BITS-1:0] step_rgb;
  logic [LEVEL_BITS-1:0] step_saturation;
  logic [LEVEL_BITS-1:0] step_hue;
  logic [LEVEL_BITS-1:0] step_center;
  logic [LEVEL_BITS-1:0] step_width;

  logic advance;
  logic copy;

  aems_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .alphas (alphas)
  );

  aems_channel #(.LEVEL_BITS(LEVEL_BITS), .CIRCULAR(1'b0)) u_white (
    .cur (held_white), .goal (in_white),
    .rise_alpha (alphas.white_rise), .fall_alpha (alphas.white_fall),
    .next (step_white)
  );

  aems_channel #(.LEVEL_BITS(LEVEL_BITS), .CIRCULAR(1'b0)) u_rgb (
    .cur (held_rgb), .goal (in_rgb),
    .rise_alpha (alphas.rgb_rise), .fall_alpha (alphas.rgb_fall),
    .next (step_rgb)
  );

  aems_channel #(.LEVEL_BITS(LEVEL_BITS), .CIRCULAR(1'b0)) u_saturation (
    .cur (held_saturation), .goal (in_saturation),
    .rise_alpha (alphas.saturation), .fall_alpha (alphas.saturation),
    .next (step_saturation)
  );

  aems_channel #(.LEVEL_BITS(LEVEL_BITS), .CIRCULAR(1'b1)) u_hue (
    .cur (held_hue), .goal (in_hue),
    .rise_alpha (alphas.hue), .fall_alpha (alphas.hue),
    .next (step_hue)
  );

  aems_channel #(.LEVEL_BITS(LEVEL_BITS), .CIRCULAR(1'b0)) u_center (
    .cur (held_center), .goal (in_center),
    .rise_alpha (alphas.center), .fall_alpha (alphas.center),
    .next (step_center)
  );

  aems_channel #(.LEVEL_BITS(LEVEL_BITS), .CIRCULAR(1'b0)) u_width (
    .cur (held_width), .goal (in_width),
    .rise_alpha (alphas.width), .fall_alpha (alphas.width),
    .next (step_width)
  );

  // The item in the input register moves on when the result register is
  // empty or its contents are being transferred out in this cycle.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign goal.ready = !in_valid || advance;
  assign copy       = !primed || in_restart;

  assign result.valid          = out_valid;
  assign result.out_white      = held_white;
  assign result.out_rgb        = held_rgb;
  assign result.out_saturation = held_saturation;
  assign result.out_hue        = held_hue;
  assign result.out_center     = held_center;
  assign result.out_width      = held_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      primed    <= 1'b0;
    end else begin
      if (goal.valid && goal.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
        primed    <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk) begin
    if (goal.valid && goal.ready) begin
      in_restart    <= goal.restart;
      in_white      <= goal.goal_white;
      in_rgb        <= goal.goal_rgb;
      in_saturation <= goal.goal_saturation;
      in_hue        <= goal.goal_hue;
      in_center     <= goal.goal_center;
      in_width      <= goal.goal_width;
    end
  end

  // Held values: a copied goal when there is no history or restart is set, else one step.
  always_ff @(posedge clk) begin
    if (advance) begin
      held_white      <= copy ? in_white      : step_white;
      held_rgb        <= copy ? in_rgb        : step_rgb;
      held_saturation <= copy ? in_saturation : step_saturation;
      held_hue        <= copy ? in_hue        : step_hue;
      held_center     <= copy ? in_center     : step_center;
      held_width      <= copy ? in_width      : step_width;
    end
  end

endmodule

// ===== dv/asymmetric_ema_light_smoother_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asymmetric_ema_light_smoother_tb: self-checking bench for the light smoother
// Drives goal items and alpha register writes. A local model of the six
// channel smoothers predicts every result, and a checker compares each
// result transfer against the oldest prediction. The run covers directed
// extremes, hue ties and wrap, random traffic under changing back-pressure,
// and a long receiver stall.
// ----------------------------------------------------------------------------
module asymmetric_ema_light_smoother_tb;
  import aems_pkg::*;

  localparam int LEVEL_BITS = 16;
  localparam int LEVEL_MAX  = (1 << LEVEL_BITS) - 1;
  localparam int TURN       = 1 << LEVEL_BITS;
  localparam int HALF_TURN  = TURN / 2;

  // Indexes past the register list; writes there must leave every alpha alone.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = 4'd8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LAST  = 4'd15;

  localparam logic [ALPHA_W-1:0] ALPHA_ZERO     = '0;
  localparam logic [ALPHA_W-1:0] ALPHA_HALF     = ALPHA_ONE >> 1;
  // All 17 bits set: well above one, so the block must treat it as one.
  localparam logic [ALPHA_W-1:0] ALPHA_OVERSIZE = '1;

  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;
  localparam int STALL_CYCLES  = 200;

  typedef struct packed {
    logic                  restart;
    logic [LEVEL_BITS-1:0] white;
    logic [LEVEL_BITS-1:0] rgb;
    logic [LEVEL_BITS-1:0] saturation;
    logic [LEVEL_BITS-1:0] hue;
    logic [LEVEL_BITS-1:0] center;
    logic [LEVEL_BITS-1:0] width;
  } goal_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] white;
    logic [LEVEL_BITS-1:0] rgb;
    logic [LEVEL_BITS-1:0] saturation;
    logic [LEVEL_BITS-1:0] hue;
    logic [LEVEL_BITS-1:0] center;
    logic [LEVEL_BITS-1:0] width;
  } levels_t;

  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  aems_goal_if   #(.LEVEL_BITS(LEVEL_BITS)) goal_ch ();
  aems_result_if #(.LEVEL_BITS(LEVEL_BITS)) result_ch ();
  aems_cfg_if                               cfg_ch ();

  asymmetric_ema_light_smoother #(.LEVEL_BITS(LEVEL_BITS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .goal   (goal_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Model state: the history flag, the held levels and the alpha registers.
  bit         primed;
  levels_t    held;
  alpha_set_t alphas;

  // Results predicted at goal transfer time and not yet seen on the output.
  levels_t pending_levels[$];

  int goals_sent;
  int results_seen;
  int alpha_writes;
  int mismatches;

  // Idle odds in percent for the goal sender and the result receiver.
  int send_idle_pct;
  int recv_idle_pct;

  // A test asks for a receiver stall by bumping stall_req; the receiver
  // process notices the change and counts the stall down itself.
  int stall_req;
  int stall_seen = 0;
  int stall_left = 0;

  // --------------------------------------------------------------------------
  // Channel model
  // --------------------------------------------------------------------------

  function automatic logic [ALPHA_W-1:0] capped(input logic [ALPHA_W-1:0] a);
    return (a > ALPHA_ONE) ? ALPHA_ONE : a;
  endfunction

  // floor(diff * alpha / 2^16): an arithmetic shift of a signed product
  // rounds toward minus infinity.
  function automatic longint weighted_step(input longint diff,
                                           input logic [ALPHA_W-1:0] a);
    longint prod;
    prod = diff * longint'(capped(a));
    return prod >>> ALPHA_BITS;
  endfunction

  function automatic logic [LEVEL_BITS-1:0] level_toward(
      input logic [LEVEL_BITS-1:0] cur, input logic [LEVEL_BITS-1:0] goal,
      input logic [ALPHA_W-1:0] rise, input logic [ALPHA_W-1:0] fall);
    longint diff;
    logic [ALPHA_W-1:0] a;
    a = (goal >= cur) ? rise : fall;
    diff = longint'(goal) - longint'(cur);
    return LEVEL_BITS'(longint'(cur) + weighted_step(diff, a));
  endfunction

  // Hue takes the short way round; exactly half a turn keeps the raw sign.
  function automatic logic [LEVEL_BITS-1:0] hue_toward(
      input logic [LEVEL_BITS-1:0] cur, input logic [LEVEL_BITS-1:0] goal,
      input logic [ALPHA_W-1:0] a);
    longint diff;
    diff = longint'(goal) - longint'(cur);
    if (diff > HALF_TURN) begin
      diff -= TURN;
    end else if (diff < -HALF_TURN) begin
      diff += TURN;
    end
    return LEVEL_BITS'(longint'(cur) + weighted_step(diff, a));
  endfunction

  task automatic advance_held(input goal_t g, output levels_t r);
    if (!primed || g.restart) begin
      held = '{g.white, g.rgb, g.saturation, g.hue, g.center, g.width};
      primed = 1'b1;
    end else begin
      held.white      = level_toward(held.white, g.white,
                                     alphas.white_rise, alphas.white_fall);
      held.rgb        = level_toward(held.rgb, g.rgb,
                                     alphas.rgb_rise, alphas.rgb_fall);
      held.saturation = level_toward(held.saturation, g.saturation,
                                     alphas.saturation, alphas.saturation);
      held.hue        = hue_toward(held.hue, g.hue, alphas.hue);
      held.center     = level_toward(held.center, g.center,
                                     alphas.center, alphas.center);
      held.width      = level_toward(held.width, g.width,
                                     alphas.width, alphas.width);
    end
    r = held;
  endtask

  task automatic apply_alpha_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                   input logic [ALPHA_W-1:0] value);
    case (idx)
      REG_WHITE_RISE: alphas.white_rise = value;
      REG_WHITE_FALL: alphas.white_fall = value;
      REG_RGB_RISE:   alphas.rgb_rise   = value;
      REG_RGB_FALL:   alphas.rgb_fall   = value;
      REG_SATURATION: alphas.saturation = value;
      REG_HUE:        alphas.hue        = value;
      REG_CENTER:     alphas.center     = value;
      REG_WIDTH:      alphas.width      = value;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic goal_t mk_goal(input logic restart,
      input int w, input int r, input int s, input int h, input int c,
      input int wd);
    return '{restart, LEVEL_BITS'(w), LEVEL_BITS'(r), LEVEL_BITS'(s),
             LEVEL_BITS'(h), LEVEL_BITS'(c), LEVEL_BITS'(wd)};
  endfunction

  // Mix the range ends, small moves around the held value and full random.
  function automatic logic [LEVEL_BITS-1:0] pick_level(
      input logic [LEVEL_BITS-1:0] cur);
    case ($urandom_range(7))
      0:       return '0;
      1:       return LEVEL_BITS'(LEVEL_MAX);
      2, 3:    return cur + LEVEL_BITS'($urandom_range(300))
                          - LEVEL_BITS'($urandom_range(300));
      default: return LEVEL_BITS'($urandom);
    endcase
  endfunction

  // Hue also aims at exactly half a turn away, and one step either side.
  function automatic logic [LEVEL_BITS-1:0] pick_hue(
      input logic [LEVEL_BITS-1:0] cur);
    case ($urandom_range(7))
      0:       return cur + LEVEL_BITS'(HALF_TURN);
      1:       return cur + LEVEL_BITS'(HALF_TURN) + LEVEL_BITS'($urandom_range(2))
                          - LEVEL_BITS'(1);
      default: return pick_level(cur);
    endcase
  endfunction

  function automatic goal_t random_goal();
    goal_t g;
    g.restart    = ($urandom_range(19) == 0);
    g.white      = pick_level(held.white);
    g.rgb        = pick_level(held.rgb);
    g.saturation = pick_level(held.saturation);
    g.hue        = pick_hue(held.hue);
    g.center     = pick_level(held.center);
    g.width      = pick_level(held.width);
    return g;
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(9))
      0:       return ALPHA_ZERO;
      1:       return ALPHA_ONE;
      2:       return ALPHA_OVERSIZE;
      3:       return ALPHA_W'($urandom);
      4:       return ALPHA_ONE - 1'b1;
      default: return ALPHA_W'($urandom_range(12000, 1));
    endcase
  endfunction

  // One register write; valid is dropped after each transfer.
  task automatic write_alpha(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [ALPHA_W-1:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_alpha_write(idx, value);
    alpha_writes++;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_alphas(input alpha_set_t s);
    write_alpha(REG_WHITE_RISE, s.white_rise);
    write_alpha(REG_WHITE_FALL, s.white_fall);
    write_alpha(REG_RGB_RISE,   s.rgb_rise);
    write_alpha(REG_RGB_FALL,   s.rgb_fall);
    write_alpha(REG_SATURATION, s.saturation);
    write_alpha(REG_HUE,        s.hue);
    write_alpha(REG_CENTER,     s.center);
    write_alpha(REG_WIDTH,      s.width);
  endtask

  // Offers one goal, with random idle cycles ahead of it, and records the
  // predicted result once the transfer happens. Valid stays high on return
  // so back-to-back goals need no extra assignment in the same step.
  task automatic send_goal(input goal_t g);
    levels_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      goal_ch.valid <= 1'b0;
      @(posedge clk);
    end
    goal_ch.valid           <= 1'b1;
    goal_ch.restart         <= g.restart;
    goal_ch.goal_white      <= g.white;
    goal_ch.goal_rgb        <= g.rgb;
    goal_ch.goal_saturation <= g.saturation;
    goal_ch.goal_hue        <= g.hue;
    goal_ch.goal_center     <= g.center;
    goal_ch.goal_width      <= g.width;
    @(posedge clk);
    while (!goal_ch.ready) @(posedge clk);
    advance_held(g, predicted);
    pending_levels.push_back(predicted);
    goals_sent++;
  endtask

  // Stops offering goals and waits for every predicted result, then lets the
  // pipeline settle so it is empty before any register write.
  task automatic drain_results();
    int waited;
    goal_ch.valid <= 1'b0;
    waited = 0;
    while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_levels.size() != 0) begin
      $display("%0d predicted results never arrived", pending_levels.size());
      mismatches += pending_levels.size();
      pending_levels.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset alphas stay in place: the first goal copies through, then the
  // levels take one default step up and one down.
  task automatic test_reset_defaults();
    send_goal(mk_goal(1'b0, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, 16'h5555,
                      16'hAAAA));
    send_goal(mk_goal(1'b0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX,
                      LEVEL_MAX, LEVEL_MAX));
    send_goal(mk_goal(1'b0, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  // Alpha of one copies the goal, zero freezes the levels, and an oversize
  // value must act as one. Spare index writes of zero must not land anywhere.
  task automatic test_alpha_extremes();
    write_all_alphas('{default: ALPHA_ONE});
    send_goal(random_goal());
    send_goal(mk_goal(1'b0, LEVEL_MAX, 0, LEVEL_MAX, 0, LEVEL_MAX, 0));
    drain_results();
    write_all_alphas('{default: ALPHA_ZERO});
    send_goal(mk_goal(1'b0, 0, LEVEL_MAX, 0, LEVEL_MAX, 0, LEVEL_MAX));
    send_goal(random_goal());
    drain_results();
    write_all_alphas('{default: ALPHA_OVERSIZE});
    write_alpha(REG_SPARE_FIRST, ALPHA_ZERO);
    write_alpha(REG_SPARE_LAST, ALPHA_ZERO);
    send_goal(random_goal());
    send_goal(mk_goal(1'b0, 0, LEVEL_MAX, 0, LEVEL_MAX, 0, LEVEL_MAX));
    drain_results();
  endtask

  // Split rise and fall rates, hue exactly half a turn away in both
  // directions, and hue steps that cross zero both ways.
  task automatic test_hue_wrap_and_ties();
    write_all_alphas('{white_rise: ALPHA_ONE, white_fall: ALPHA_ZERO,
                       rgb_rise: ALPHA_ZERO, rgb_fall: ALPHA_ONE,
                       saturation: ALPHA_HALF, hue: ALPHA_HALF,
                       center: ALPHA_W'(1), width: ALPHA_ONE - 1'b1});
    send_goal(mk_goal(1'b1, 16'h8000, 16'h8000, 0, 0, 0, 0));
    send_goal(mk_goal(1'b0, LEVEL_MAX, 0, LEVEL_MAX, 16'h8000, LEVEL_MAX,
                      LEVEL_MAX));
    send_goal(mk_goal(1'b0, 0, LEVEL_MAX, 0, 16'hC000, 0, 0));
    send_goal(mk_goal(1'b1, 16'h00FF, 16'hFF00, 16'h1000, 16'h8000, 16'h7FFF,
                      16'h8001));
    send_goal(mk_goal(1'b0, 16'h0100, 16'hFEFF, 16'h1001, 0, 16'h8000,
                      16'h8000));
    send_goal(mk_goal(1'b1, 0, 0, 0, 65000, 0, 0));
    send_goal(mk_goal(1'b0, 0, 0, 0, 100, 0, 0));
    send_goal(mk_goal(1'b1, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 100, LEVEL_MAX,
                      LEVEL_MAX));
    send_goal(mk_goal(1'b0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 65000, LEVEL_MAX,
                      LEVEL_MAX));
    drain_results();
  endtask

  // Fresh random alphas, a stray write to a spare index, then a long run
  // of random goals under the given idle odds.
  task automatic test_random_traffic(input int count, input int send_pct,
                                     input int recv_pct);
    alpha_set_t s;
    s = '{pick_alpha(), pick_alpha(), pick_alpha(), pick_alpha(),
          pick_alpha(), pick_alpha(), pick_alpha(), pick_alpha()};
    write_all_alphas(s);
    write_alpha(CFG_INDEX_BITS'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                ALPHA_W'($urandom));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_goal(random_goal());
    drain_results();
  endtask

  // The receiver stops for a long stretch while goals keep coming, so both
  // stages fill and goal ready drops; then the sender waits for every
  // result before a final burst.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req++;
    repeat (16) send_goal(random_goal());
    drain_results();
    repeat (8) send_goal(random_goal());
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin : result_check
    levels_t got;
    levels_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.out_white, result_ch.out_rgb, result_ch.out_saturation,
              result_ch.out_hue, result_ch.out_center, result_ch.out_width};
      results_seen++;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result %0d arrived with nothing predicted: %h", results_seen,
                   got);
        end
      end else begin
        want = pending_levels.pop_front();
        if (got.white !== want.white || got.rgb !== want.rgb ||
            got.saturation !== want.saturation || got.hue !== want.hue ||
            got.center !== want.center || got.width !== want.width) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d: exp w=%h r=%h s=%h h=%h c=%h wd=%h", results_seen,
                     want.white, want.rgb, want.saturation, want.hue, want.center,
                     want.width);
            $display("result %0d: got w=%h r=%h s=%h h=%h c=%h wd=%h", results_seen,
                     got.white, got.rgb, got.saturation, got.hue, got.center,
                     got.width);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    // Known values on every driven input before the first edge; the result
    // ready comes from the receiver process from the first edge on.
    rst                     = 1'b1;
    goal_ch.valid           = 1'b0;
    goal_ch.restart         = 1'b0;
    goal_ch.goal_white      = '0;
    goal_ch.goal_rgb        = '0;
    goal_ch.goal_saturation = '0;
    goal_ch.goal_hue        = '0;
    goal_ch.goal_center     = '0;
    goal_ch.goal_width      = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.reg_index        = '0;
    cfg_ch.data             = '0;

    primed        = 1'b0;
    held          = '0;
    alphas        = '{default: ALPHA_RESET};
    goals_sent    = 0;
    results_seen  = 0;
    alpha_writes  = 0;
    mismatches    = 0;
    stall_req     = 0;
    send_idle_pct = 23;
    recv_idle_pct = 53;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_alpha_extremes();
    test_hue_wrap_and_ties();
    test_random_traffic(125, 23, 53);
    test_random_traffic(125, 53, 23);
    test_random_traffic(125, 0, 0);
    test_backpressure();

    $display("covered %0d goals, %0d results and %0d alpha writes", goals_sent,
             results_seen, alpha_writes);
    $display("including range ends, hue ties and wrap, and a long result stall");
    if (mismatches == 0) begin
      $display("asymmetric_ema_light_smoother_tb: clean");
    end else begin
      $display("asymmetric_ema_light_smoother_tb: errors");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("asymmetric_ema_light_smoother_tb: errors");
    $finish;
  end

endmodule

// ===== asymmetric_ema_light_smoother.f =====
rtl/aems_pkg.sv
rtl/aems_if.sv
rtl/aems_cfg_regs.sv
rtl/aems_channel.sv
rtl/asymmetric_ema_light_smoother.sv
dv/asymmetric_ema_light_smoother_tb.sv
